FILE: rtl/point_stream_coplanarity_check_top_defines.svh
// assertion macros for the coplanarity check block
// used by the top level only; no other dependencies
`ifndef POINT_STREAM_COPLANARITY_CHECK_TOP_DEFINES_SVH
`define POINT_STREAM_COPLANARITY_CHECK_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CPC_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpc assertion failed");
`define CPC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpc assertion failed");
`else
`define CPC_ASSERT_IMPL(name, clk, rst, ante, cons)
`define CPC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/cpc_pkg.sv
// shared types, microcode word layout and program addresses
// no dependencies; used by every module of the coplanarity check
package cpc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FIELD_W = 16;
  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] A_DISPATCH = 4'd0;
  localparam logic [PC_W-1:0] A_CROSS    = 4'd1;
  localparam logic [PC_W-1:0] A_COMMIT   = 4'd8;
  localparam logic [PC_W-1:0] A_RESID    = 4'd9;
  localparam logic [PC_W-1:0] A_FINISH   = 4'd13;

  typedef enum logic [1:0] {
    PH_ANCHOR,
    PH_SECOND,
    PH_SEARCH,
    PH_PLANE
  } phase_t;

  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_CROSS,
    JOB_RESID
  } job_t;

  typedef enum logic [2:0] {
    OPA_U0,
    OPA_U1,
    OPA_U2,
    OPA_N0,
    OPA_N1,
    OPA_N2
  } opa_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    FLOW_NEXT,
    FLOW_JUMP,
    FLOW_DISPATCH,
    FLOW_END
  } flow_t;

  typedef struct packed {
    opa_t            opa;
    logic [1:0]      opb;
    acc_op_t         acc_op;
    logic            wr_n;
    logic [1:0]      wr_idx;
    logic            chk;
    logic            commit;
    flow_t           flow;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic   valid;
    uword_t uw;
  } ctl_t;

  typedef struct packed {
    job_t job;
    logic end_ok;
  } stat_t;

endpackage

FILE: rtl/point_stream_coplanarity_check_top.sv
// coplanarity check over a stream of signed 3d points; top level
// depends on cpc_pkg, cpc_ucode_rom, cpc_sequencer, cpc_datapath and the defines header
// one item at a time: dispatch and finish steps only before a plane search starts;
// while searching also the cross product (on one multiplier) and commit steps,
// once the plane is fixed the residual steps; a final item holds its last
// step while an earlier result is not taken; rst clears set state and sequencer
`include "point_stream_coplanarity_check_top_defines.svh"
module point_stream_coplanarity_check_top #(
  parameter int COORD_WIDTH = cpc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [3*cpc_pkg::FIELD_W-1:0] s_tdata,  // px, py, pz
  input  logic                          s_tlast,  // final_point
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata   // coplanar, zero fill
);

  logic                     accept;
  logic                     busy;
  logic                     coplanar;
  logic                     dispatching;
  logic                     at_end;
  logic [cpc_pkg::PC_W-1:0] pc;
  cpc_pkg::uword_t          uw;
  cpc_pkg::ctl_t            ctl;
  cpc_pkg::stat_t           stat;

  assign s_tready    = !busy && !rst;
  assign accept      = s_tvalid && s_tready;
  assign m_tdata     = {7'd0, coplanar};
  assign dispatching = ctl.valid && (ctl.uw.flow == cpc_pkg::FLOW_DISPATCH);
  assign at_end      = ctl.valid && (ctl.uw.flow == cpc_pkg::FLOW_END);

  cpc_ucode_rom u_rom (
    .pc (pc),
    .uw (uw)
  );

  cpc_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .uw    (uw),
    .stat  (stat),
    .pc    (pc),
    .ctl   (ctl),
    .busy  (busy)
  );

  cpc_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_data      (s_tdata),
    .in_last      (s_tlast),
    .ctl          (ctl),
    .out_ready    (m_tready),
    .stat         (stat),
    .out_valid    (m_tvalid),
    .out_coplanar (coplanar)
  );

  `CPC_ASSERT_NEXT(a_start_dispatch, clk, rst, accept, dispatching)
  `CPC_ASSERT_NEXT(a_end_idle, clk, rst, at_end && stat.end_ok, s_tready)
  `CPC_ASSERT_IMPL(a_result_from_end, clk, rst, $rose(m_tvalid), $past(at_end))

endmodule

FILE: rtl/cpc_ucode_rom.sv
// microcode table: cross product, commit, plane residual and finish steps
// depends on cpc_pkg
module cpc_ucode_rom (
  input  logic [cpc_pkg::PC_W-1:0] pc,
  output cpc_pkg::uword_t          uw
);

  function automatic cpc_pkg::uword_t mk(
    input cpc_pkg::opa_t            a,
    input logic [1:0]               b,
    input cpc_pkg::acc_op_t         op,
    input logic                     wr,
    input logic [1:0]               idx,
    input logic                     chk,
    input logic                     cm,
    input cpc_pkg::flow_t           fl,
    input logic [cpc_pkg::PC_W-1:0] tg
  );
    cpc_pkg::uword_t r;
    r.opa    = a;
    r.opb    = b;
    r.acc_op = op;
    r.wr_n   = wr;
    r.wr_idx = idx;
    r.chk    = chk;
    r.commit = cm;
    r.flow   = fl;
    r.target = tg;
    return r;
  endfunction

  localparam logic [cpc_pkg::PC_W-1:0] ONE = 4'd1;

  always_comb begin
    unique case (pc)
      cpc_pkg::A_DISPATCH:
        uw = mk(cpc_pkg::OPA_U0, 2'd0, cpc_pkg::ACC_HOLD, 1'b0, 2'd0, 1'b0, 1'b0,
                cpc_pkg::FLOW_DISPATCH, cpc_pkg::A_FINISH);
      // n0 = u1*w2 - u2*w1
      cpc_pkg::A_CROSS:
        uw = mk(cpc_pkg::OPA_U1, 2'd2, cpc_pkg::ACC_HOLD, 1'b0, 2'd0, 1'b0, 1'b0,
                cpc_pkg::FLOW_NEXT, cpc_pkg::A_FINISH);
      cpc_pkg::A_CROSS + ONE:
        uw = mk(cpc_pkg::OPA_U2, 2'd1, cpc_pkg::ACC_LOAD, 1'b0, 2'd0, 1'b0, 1'b0,
                cpc_pkg::FLOW_NEXT, cpc_pkg::A_FINISH);
      // n1 = u2*w0 - u0*w2
      cpc_pkg::A_CROSS + 4'd2:
        uw = mk(cpc_pkg::OPA_U2, 2'd0, cpc_pkg::ACC_SUB, 1'b1, 2'd0, 1'b0, 1'b0,
                cpc_pkg::FLOW_NEXT, cpc_pkg::A_FINISH);
      cpc_pkg::A_CROSS + 4'd3:
        uw = mk(cpc_pkg::OPA_U0, 2'd2, cpc_pkg::ACC_LOAD, 1'b0, 2'd0, 1'b0, 1'b0,
                cpc_pkg::FLOW_NEXT, cpc_pkg::A_FINISH);
      // n2 = u0*w1 - u1*w0
      cpc_pkg::A_CROSS + 4'd4:
        uw = mk(cpc_pkg::OPA_U0, 2'd1, cpc_pkg::ACC_SUB, 1'b1, 2'd1, 1'b0, 1'b0,
                cpc_pkg::FLOW_NEXT, cpc_pkg::A_FINISH);
      cpc_pkg::A_CROSS + 4'd5:
        uw = mk(cpc_pkg::OPA_U1, 2'd0, cpc_pkg::ACC_LOAD, 1'b0, 2'd0, 1'b0, 1'b0,
                cpc_pkg::FLOW_NEXT, cpc_pkg::A_FINISH);
      cpc_pkg::A_CROSS + 4'd6:
        uw = mk(cpc_pkg::OPA_U0, 2'd0, cpc_pkg::ACC_SUB, 1'b1, 2'd2, 1'b0, 1'b0,
                cpc_pkg::FLOW_NEXT, cpc_pkg::A_FINISH);
      cpc_pkg::A_COMMIT:
        uw = mk(cpc_pkg::OPA_U0, 2'd0, cpc_pkg::ACC_HOLD, 1'b0, 2'd0, 1'b0, 1'b1,
                cpc_pkg::FLOW_JUMP, cpc_pkg::A_FINISH);
      // residual n . (p - anchor)
      cpc_pkg::A_RESID:
        uw = mk(cpc_pkg::OPA_N0, 2'd0, cpc_pkg::ACC_HOLD, 1'b0, 2'd0, 1'b0, 1'b0,
                cpc_pkg::FLOW_NEXT, cpc_pkg::A_FINISH);
      cpc_pkg::A_RESID + ONE:
        uw = mk(cpc_pkg::OPA_N1, 2'd1, cpc_pkg::ACC_LOAD, 1'b0, 2'd0, 1'b0, 1'b0,
                cpc_pkg::FLOW_NEXT, cpc_pkg::A_FINISH);
      cpc_pkg::A_RESID + 4'd2:
        uw = mk(cpc_pkg::OPA_N2, 2'd2, cpc_pkg::ACC_ADD, 1'b0, 2'd0, 1'b0, 1'b0,
                cpc_pkg::FLOW_NEXT, cpc_pkg::A_FINISH);
      cpc_pkg::A_RESID + 4'd3:
        uw = mk(cpc_pkg::OPA_N0, 2'd0, cpc_pkg::ACC_ADD, 1'b0, 2'd0, 1'b1, 1'b0,
                cpc_pkg::FLOW_JUMP, cpc_pkg::A_FINISH);
      default:
        uw = mk(cpc_pkg::OPA_U0, 2'd0, cpc_pkg::ACC_HOLD, 1'b0, 2'd0, 1'b0, 1'b0,
                cpc_pkg::FLOW_END, cpc_pkg::A_FINISH);
    endcase
  end

endmodule

FILE: rtl/cpc_sequencer.sv
// step counter and jump logic of the microcoded controller
// depends on cpc_pkg; reads control words from cpc_ucode_rom
module cpc_sequencer (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  cpc_pkg::uword_t          uw,
  input  cpc_pkg::stat_t           stat,
  output logic [cpc_pkg::PC_W-1:0] pc,
  output cpc_pkg::ctl_t            ctl,
  output logic                     busy
);

  logic [cpc_pkg::PC_W-1:0] pc_next;
  logic                     done;

  always_comb begin
    unique case (uw.flow)
      cpc_pkg::FLOW_NEXT: pc_next = pc + cpc_pkg::PC_W'(1);
      cpc_pkg::FLOW_JUMP: pc_next = uw.target;
      cpc_pkg::FLOW_DISPATCH: begin
        unique case (stat.job)
          cpc_pkg::JOB_CROSS: pc_next = cpc_pkg::A_CROSS;
          cpc_pkg::JOB_RESID: pc_next = cpc_pkg::A_RESID;
          default:            pc_next = cpc_pkg::A_FINISH;
        endcase
      end
      default: pc_next = pc;
    endcase
  end

  assign done      = (uw.flow == cpc_pkg::FLOW_END) && stat.end_ok;
  assign ctl.valid = busy;
  assign ctl.uw    = uw;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= cpc_pkg::A_DISPATCH;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= cpc_pkg::A_DISPATCH;
    end else if (busy) begin
      if (done) begin
        busy <= 1'b0;
      end
      pc <= pc_next;
    end
  end

endmodule

FILE: rtl/cpc_datapath.sv
// point registers, shared multiplier, accumulator, set state and result register
// depends on cpc_pkg; driven by the control word from cpc_sequencer
module cpc_datapath #(
  parameter int COORD_WIDTH = cpc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [3*cpc_pkg::FIELD_W-1:0] in_data,
  input  logic                          in_last,
  input  cpc_pkg::ctl_t                 ctl,
  input  logic                          out_ready,
  output cpc_pkg::stat_t                stat,
  output logic                          out_valid,
  output logic                          out_coplanar
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int NW = 2 * DW + 1;
  localparam int PW = NW + DW;
  localparam int AW = PW + 2;

  logic signed [COORD_WIDTH-1:0] pt     [3];
  logic signed [COORD_WIDTH-1:0] anchor [3];
  logic signed [DW-1:0]          diff   [3];
  logic signed [DW-1:0]          u      [3];
  logic signed [DW-1:0]          w      [3];
  logic signed [NW-1:0]          nrm    [3];
  logic signed [NW-1:0]          mul_a;
  logic signed [DW-1:0]          mul_b;
  logic signed [PW-1:0]          prod;
  logic signed [AW-1:0]          acc;
  logic signed [AW-1:0]          acc_next;
  cpc_pkg::phase_t               phase;
  cpc_pkg::phase_t               phase_next;
  cpc_pkg::job_t                 job;
  logic                          all_on;
  logic                          final_q;
  logic                          differs;
  logic                          nrm_nz;
  logic                          room;
  logic                          finish;

  always_comb begin
    logic signed [31:0] ext;
    ext     = '0;
    differs = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ext     = 32'(signed'(in_data[i*cpc_pkg::FIELD_W +: cpc_pkg::FIELD_W]));
      pt[i]   = ext[COORD_WIDTH-1:0];
      diff[i] = DW'(pt[i]) - DW'(anchor[i]);
      differs = differs | (pt[i] != anchor[i]);
    end
  end

  always_comb begin
    unique case (ctl.uw.opa)
      cpc_pkg::OPA_U0: mul_a = NW'(u[0]);
      cpc_pkg::OPA_U1: mul_a = NW'(u[1]);
      cpc_pkg::OPA_U2: mul_a = NW'(u[2]);
      cpc_pkg::OPA_N0: mul_a = nrm[0];
      cpc_pkg::OPA_N1: mul_a = nrm[1];
      cpc_pkg::OPA_N2: mul_a = nrm[2];
      default:         mul_a = '0;
    endcase
    case (ctl.uw.opb)
      2'd1:    mul_b = w[1];
      2'd2:    mul_b = w[2];
      default: mul_b = w[0];
    endcase
    unique case (ctl.uw.acc_op)
      cpc_pkg::ACC_LOAD: acc_next = AW'(prod);
      cpc_pkg::ACC_ADD:  acc_next = acc + AW'(prod);
      cpc_pkg::ACC_SUB:  acc_next = acc - AW'(prod);
      default:           acc_next = acc;
    endcase
  end

  assign nrm_nz      = (nrm[0] != '0) || (nrm[1] != '0) || (nrm[2] != '0);
  assign room        = !out_valid || out_ready;
  assign stat.end_ok = !final_q || room;
  assign stat.job    = job;
  assign finish      = ctl.valid && (ctl.uw.flow == cpc_pkg::FLOW_END) && stat.end_ok;

  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        cpc_pkg::PH_ANCHOR: phase_next = cpc_pkg::PH_SECOND;
        cpc_pkg::PH_SECOND: begin
          if (differs) begin
            phase_next = cpc_pkg::PH_SEARCH;
          end
        end
        default: phase_next = phase;
      endcase
    end
    if (ctl.valid && ctl.uw.commit && nrm_nz) begin
      phase_next = cpc_pkg::PH_PLANE;
    end
    if (finish && final_q) begin
      phase_next = cpc_pkg::PH_ANCHOR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= cpc_pkg::PH_ANCHOR;
      job       <= cpc_pkg::JOB_NONE;
      all_on    <= 1'b1;
      final_q   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        final_q <= in_last;
        unique case (phase)
          cpc_pkg::PH_SEARCH: job <= cpc_pkg::JOB_CROSS;
          cpc_pkg::PH_PLANE:  job <= cpc_pkg::JOB_RESID;
          default:            job <= cpc_pkg::JOB_NONE;
        endcase
      end
      if (finish && final_q) begin
        all_on <= 1'b1;
      end else if (ctl.valid && ctl.uw.chk && (acc_next != '0)) begin
        all_on <= 1'b0;
      end
      if (finish && final_q) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      unique case (phase)
        cpc_pkg::PH_ANCHOR: anchor <= pt;
        cpc_pkg::PH_SECOND: begin
          if (differs) begin
            u <= diff;
          end
        end
        default: w <= diff;
      endcase
    end
    if (ctl.valid) begin
      prod <= mul_a * mul_b;
      acc  <= acc_next;
      for (int i = 0; i < 3; i++) begin
        if (ctl.uw.wr_n && (ctl.uw.wr_idx == 2'(i))) begin
          nrm[i] <= NW'(acc_next);
        end
      end
    end
    if (finish && final_q) begin
      out_coplanar <= all_on;
    end
  end

endmodule
